// ===== hw/rtl/rodr_pkg.sv =====
// Shared types and constants for the axis-angle to rotation matrix unit.
// Holds the sine series constants, pipeline latencies and the sign bundle.
// Has no dependencies.
package rodr_pkg;

  localparam int FRAC_BITS_DEF = 14;

  // Angle in 1/64 degree units.
  localparam int UW = 13;                    // folded angle, 0..5760
  localparam int RW_ANG = 15;                // reduced angle, 0..23039
  localparam logic [17:0] FULL_TURN = 18'd23040;
  localparam logic [17:0] QUARTER_TURN = 18'd5760;

  // Sine magnitude in unsigned Q30 (0..2^30).
  localparam int QW = 31;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [28:0] SIN_K = 29'd299845282;  // pi/11520 in Q40

  localparam int SIN_STEPS = 7;
  localparam logic [7:0] SIN_DIV [0:SIN_STEPS-1] =
    '{8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] SIN_RECIP [0:SIN_STEPS-1] = '{
    30'(64'h1_0000_0000 / 64'd210), 30'(64'h1_0000_0000 / 64'd156),
    30'(64'h1_0000_0000 / 64'd110), 30'(64'h1_0000_0000 / 64'd72),
    30'(64'h1_0000_0000 / 64'd42),  30'(64'h1_0000_0000 / 64'd20),
    30'(64'h1_0000_0000 / 64'd6)};

  localparam int ANG_LAT = 2;
  localparam int SIN_LAT = 3 + 3 * SIN_STEPS;
  localparam int ENT_LAT = 4;

  typedef struct packed {
    logic neg_s;
    logic neg_c;
  } sign_t;

endpackage

// ===== hw/rtl/rodr_angle.sv =====
// Angle reduction and quadrant folding, two register stages.
// Depends on rodr_pkg.
module rodr_angle (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [15:0]      angle_deg,
  output logic [rodr_pkg::UW-1:0] u_s,
  output logic [rodr_pkg::UW-1:0] u_c,
  output rodr_pkg::sign_t         sgn
);
  import rodr_pkg::*;

  logic [17:0] biased;
  logic [17:0] red_comb;
  logic [RW_ANG-1:0] red;
  logic [17:0] r18;

  always_comb begin
    // Bias into the positive range, then remove whole turns.
    biased = 18'($signed({{2{angle_deg[15]}}, angle_deg}) + 18'sd46080);
    if (biased >= 18'd69120) begin
      red_comb = biased - 18'd69120;
    end else if (biased >= 18'd46080) begin
      red_comb = biased - 18'd46080;
    end else if (biased >= FULL_TURN) begin
      red_comb = biased - FULL_TURN;
    end else begin
      red_comb = biased;
    end
    r18 = {3'b000, red};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red <= red_comb[RW_ANG-1:0];
      if (r18 < QUARTER_TURN) begin
        u_s <= UW'(r18);
        u_c <= UW'(QUARTER_TURN - r18);
        sgn <= '{neg_s: 1'b0, neg_c: 1'b0};
      end else if (r18 < 18'd11520) begin
        u_s <= UW'(18'd11520 - r18);
        u_c <= UW'(r18 - QUARTER_TURN);
        sgn <= '{neg_s: 1'b0, neg_c: 1'b1};
      end else if (r18 < 18'd17280) begin
        u_s <= UW'(r18 - 18'd11520);
        u_c <= UW'(18'd17280 - r18);
        sgn <= '{neg_s: 1'b1, neg_c: 1'b1};
      end else begin
        u_s <= UW'(FULL_TURN - r18);
        u_c <= UW'(r18 - 18'd17280);
        sgn <= '{neg_s: 1'b1, neg_c: 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/rodr_qsin.sv =====
// Pipelined sine of a folded angle: Taylor series in Horner form, unsigned Q30.
// Each series term takes three stages; divisions use reciprocal multiply and fixup.
// Depends on rodr_pkg.
module rodr_qsin (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rodr_pkg::UW-1:0] u,
  output logic [rodr_pkg::QW-1:0] sin_q
);
  import rodr_pkg::*;

  logic [41:0] xm;
  logic [41:0] xs;
  logic [30:0] x1;
  logic [61:0] xx;
  logic [61:0] xxr;
  logic [30:0] x_r;
  logic [31:0] x2_r;

  assign xm = 42'(u) * 42'(SIN_K);
  assign xs = xm + 42'd512;
  assign xx = 62'(x1) * 62'(x1);
  assign xxr = xx + 62'h2000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= xs[40:10];
      x_r <= x1;
      x2_r <= xxr[61:30];
    end
  end

  // Per-term registers: a = product, b = quotient estimate, c = new term.
  logic [31:0] na [0:SIN_STEPS-1];
  logic [30:0] xa [0:SIN_STEPS-1];
  logic [31:0] x2a [0:SIN_STEPS-1];
  logic [31:0] nb [0:SIN_STEPS-1];
  logic [31:0] qb [0:SIN_STEPS-1];
  logic [30:0] xb [0:SIN_STEPS-1];
  logic [31:0] x2b [0:SIN_STEPS-1];
  logic [30:0] tc [0:SIN_STEPS-1];
  logic [30:0] xc [0:SIN_STEPS-1];
  logic [31:0] x2c [0:SIN_STEPS-1];

  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_term
    logic [30:0] t_in;
    logic [30:0] x_in;
    logic [31:0] x2_in;
    logic [62:0] pm;
    logic [61:0] qm;
    logic [39:0] qd;
    logic [39:0] rem;
    logic [31:0] q;

    if (i == 0) begin : g_first
      assign t_in = Q30_ONE;
      assign x_in = x_r;
      assign x2_in = x2_r;
    end else begin : g_next
      assign t_in = tc[i-1];
      assign x_in = xc[i-1];
      assign x2_in = x2c[i-1];
    end

    assign pm = 63'(x2_in) * 63'(t_in);
    assign qm = 62'(na[i]) * 62'(SIN_RECIP[i]);
    assign qd = 40'(qb[i]) * 40'(SIN_DIV[i]);
    assign rem = 40'(nb[i]) - qd;
    assign q = qb[i] + ((rem >= 40'(SIN_DIV[i])) ? 32'd1 : 32'd0);

    always_ff @(posedge clk) begin
      if (en) begin
        na[i] <= pm[61:30];
        xa[i] <= x_in;
        x2a[i] <= x2_in;
        nb[i] <= na[i];
        qb[i] <= {2'b00, qm[61:32]};
        xb[i] <= xa[i];
        x2b[i] <= x2a[i];
        tc[i] <= (q > 32'(Q30_ONE)) ? '0 : 31'(32'(Q30_ONE) - q);
        xc[i] <= xb[i];
        x2c[i] <= x2b[i];
      end
    end
  end

  logic [61:0] sm;
  assign sm = 62'(xc[SIN_STEPS-1]) * 62'(tc[SIN_STEPS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= (sm[61:30] > 32'(Q30_ONE)) ? Q30_ONE : sm[60:30];
    end
  end

endmodule

// ===== hw/rtl/rodr_entry.sv =====
// Matrix entry datapath: axis products, (1-cos) scaling, rounding and saturation.
// Four register stages. Depends on rodr_pkg.
module rodr_entry #(
  parameter int FRAC_BITS = rodr_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [rodr_pkg::QW-1:0] qs,
  input  logic [rodr_pkg::QW-1:0] qc,
  input  rodr_pkg::sign_t         sgn,
  input  logic signed [15:0]      axis_x,
  input  logic signed [15:0]      axis_y,
  input  logic signed [15:0]      axis_z,
  output logic [8:0][15:0]        m
);
  import rodr_pkg::*;

  localparam int F = FRAC_BITS;
  localparam int VW = (((64 - F) > (F + 33)) ? (64 - F) : (F + 33)) + 1;
  localparam int RW = VW - 30;
  localparam logic signed [63:0] HALF_F = 64'sd1 <<< (F - 1);
  localparam logic signed [VW-1:0] HALF_30 = VW'(64'sd1 <<< 29);
  localparam logic signed [RW-1:0] LIM = RW'(64'sd1 <<< F);
  localparam logic signed [32:0] ONE33 = 33'sh4000_0000;

  logic signed [31:0] s_c;
  logic signed [31:0] c_c;

  assign s_c = sgn.neg_s ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
  assign c_c = sgn.neg_c ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

  // Stage 1: axis products (xx, yy, zz, xy, xz, yz) and axis times sine.
  logic signed [31:0] p [0:5];
  logic signed [47:0] b1 [0:2];
  logic signed [32:0] omc;
  logic signed [31:0] c1;

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= 32'(axis_x) * 32'(axis_x);
      p[1] <= 32'(axis_y) * 32'(axis_y);
      p[2] <= 32'(axis_z) * 32'(axis_z);
      p[3] <= 32'(axis_x) * 32'(axis_y);
      p[4] <= 32'(axis_x) * 32'(axis_z);
      p[5] <= 32'(axis_y) * 32'(axis_z);
      b1[0] <= 48'(axis_x) * 48'(s_c);
      b1[1] <= 48'(axis_y) * 48'(s_c);
      b1[2] <= 48'(axis_z) * 48'(s_c);
      omc <= ONE33 - 33'(c_c);
      c1 <= c_c;
    end
  end

  // Stage 2: (1-cos) times each axis product.
  logic signed [63:0] pr [0:5];
  logic signed [47:0] b2 [0:2];
  logic signed [31:0] c2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        pr[k] <= 64'(omc) * 64'(p[k]);
      end
      b2 <= b1;
      c2 <= c1;
    end
  end

  // Stage 3: round the products to Q(F+30) and add the base terms.
  logic signed [63:0] prh [0:5];
  logic signed [VW-1:0] prs [0:5];
  logic signed [VW-1:0] cb;
  logic signed [VW-1:0] bx;
  logic signed [VW-1:0] by;
  logic signed [VW-1:0] bz;
  logic signed [VW-1:0] v [0:8];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      prh[k] = (pr[k] + HALF_F) >>> F;
      prs[k] = VW'(prh[k]);
    end
    cb = VW'(c2) <<< F;
    bx = VW'(b2[0]);
    by = VW'(b2[1]);
    bz = VW'(b2[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v[0] <= prs[0] + cb;
      v[1] <= prs[3] - bz;
      v[2] <= prs[4] + by;
      v[3] <= prs[3] + bz;
      v[4] <= prs[1] + cb;
      v[5] <= prs[5] - bx;
      v[6] <= prs[4] - by;
      v[7] <= prs[5] + bx;
      v[8] <= prs[2] + cb;
    end
  end

  // Stage 4: round to Q F and saturate to plus or minus one.
  logic signed [VW-1:0] vr [0:8];
  logic signed [RW-1:0] rr [0:8];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      vr[k] = (v[k] + HALF_30) >>> 30;
      rr[k] = RW'(vr[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        if (rr[k] > LIM) begin
          m[k] <= LIM[15:0];
        end else if (rr[k] < -LIM) begin
          m[k] <= 16'((-LIM));
        end else begin
          m[k] <= rr[k][15:0];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/axis_angle_to_rotation_matrix_unit.sv =====
// Top level of the axis-angle to rotation matrix unit.
// Depends on rodr_pkg, rodr_angle, rodr_qsin and rodr_entry.
//
// Usage:
//   The slave stream (s_tvalid, s_tready, s_tdata) carries one axis-angle item
//   per transaction: an angle in 1/64 degree units and a unit axis in Q1.14.
//   The master stream (m_tvalid, m_tready, m_tdata) returns one transaction per
//   input with the nine rotation matrix entries in row-major order, Q1.14 and
//   saturated to plus or minus one.
//   The datapath is a 30-stage pipeline: 2 stages of angle reduction, 24 stages
//   for sine and cosine (three per series term, set by the multiply, reciprocal
//   multiply and fixup of each term), and 4 stages for the matrix entries. An
//   accepted item reaches the master side through a two-entry output buffer,
//   and the unit sustains one transaction per cycle while the buffer has room.
//   The pipeline advances as a whole while the output buffer has room, so when
//   the receiver stalls the unit keeps accepting until the buffer is full and
//   then holds every stage; nothing is dropped or repeated.
//   Reset (rst, synchronous, active high) clears the valid bits and the buffer
//   count; the data registers are not reset.
module axis_angle_to_rotation_matrix_unit #(
  parameter int FRAC_BITS = rodr_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata from bit 0: angle_deg, axis_x, axis_y, axis_z (16 bits each)
  input  logic [63:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata from bit 0: m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
  output logic [143:0] m_tdata
);
  import rodr_pkg::*;

  localparam int LAT = ANG_LAT + SIN_LAT + ENT_LAT;
  localparam int AX_LAT = ANG_LAT + SIN_LAT;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } axis_t;

  logic en;
  logic [1:0] cnt;
  logic [LAT-1:0] vld;

  // The whole pipeline moves whenever the output buffer can take one more.
  assign en = (cnt != 2'd2);
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Angle to folded sine and cosine arguments.
  logic [UW-1:0] u_s;
  logic [UW-1:0] u_c;
  sign_t sgn_a;

  rodr_angle u_angle (
    .clk       (clk),
    .en        (en),
    .angle_deg (s_tdata[15:0]),
    .u_s       (u_s),
    .u_c       (u_c),
    .sgn       (sgn_a)
  );

  logic [QW-1:0] qs;
  logic [QW-1:0] qc;

  rodr_qsin u_sin (
    .clk   (clk),
    .en    (en),
    .u     (u_s),
    .sin_q (qs)
  );

  rodr_qsin u_cos (
    .clk   (clk),
    .en    (en),
    .u     (u_c),
    .sin_q (qc)
  );

  // The axis and the quadrant signs ride alongside the sine pipeline.
  axis_t ax_d [0:AX_LAT-1];
  sign_t sg_d [0:SIN_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ax_d[0] <= '{ax: s_tdata[31:16], ay: s_tdata[47:32], az: s_tdata[63:48]};
      for (int k = 1; k < AX_LAT; k++) begin
        ax_d[k] <= ax_d[k-1];
      end
      sg_d[0] <= sgn_a;
      for (int k = 1; k < SIN_LAT; k++) begin
        sg_d[k] <= sg_d[k-1];
      end
    end
  end

  logic [8:0][15:0] mat;

  rodr_entry #(
    .FRAC_BITS (FRAC_BITS)
  ) u_entry (
    .clk    (clk),
    .en     (en),
    .qs     (qs),
    .qc     (qc),
    .sgn    (sg_d[SIN_LAT-1]),
    .axis_x (ax_d[AX_LAT-1].ax),
    .axis_y (ax_d[AX_LAT-1].ay),
    .axis_z (ax_d[AX_LAT-1].az),
    .m      (mat)
  );

  // Two-entry output buffer; head is buf0.
  logic [143:0] buf0;
  logic [143:0] buf1;
  logic push;
  logic pop;

  assign push = en && vld[LAT-1];
  assign pop = m_tvalid && m_tready;
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end
    if (push && pop) begin
      if (cnt == 2'd1) begin
        buf0 <= mat;
      end else begin
        buf0 <= buf1;
        buf1 <= mat;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        buf0 <= mat;
      end else begin
        buf1 <= mat;
      end
    end else if (pop) begin
      buf0 <= buf1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    (vld[LAT-1] && en) |=> m_tvalid)
    else $error("finished item did not reach the output");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !m_tready) |=> !s_tready)
    else $error("input accepted while output buffer full");
`endif

endmodule

// ===== sim/rotation_matrix_checker.sv =====
// Checker for the axis-angle to rotation matrix unit: watches both stream channels,
// predicts each matrix from the accepted axis-angle transaction and compares entries.
// Depends on nothing but the port widths of axis_angle_to_rotation_matrix_unit.
`timescale 1ns / 1ps

module rotation_matrix_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [63:0]  s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [143:0] m_tdata,
  output int           fail_count,
  output int           matrices_pending,
  output int           matrices_checked
);

  localparam int FRAC = 14;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam int TURN = 23040;
  localparam int QUARTER = 5760;

  typedef logic [15:0] entry_t;

  logic [143:0] expected_matrices [$];

  // Sine of a folded angle 0..5760 in unsigned Q30, truncated Taylor series.
  function automatic longint series_sin(int u);
    longint unsigned divs [7];
    longint unsigned x, x2, t, q, s;
    divs = '{210, 156, 110, 72, 42, 20, 6};
    if (u < 0) u = 0;
    if (u > QUARTER) u = QUARTER;
    x = (longint'(u) * 64'd299845282 + 64'd512) >> 10;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = ONE_Q30;
    for (int i = 0; i < 7; i++) begin
      q = ((x2 * t) >> 30) / divs[i];
      t = (q > ONE_Q30) ? 0 : ONE_Q30 - q;
    end
    s = (x * t) >> 30;
    return (s > ONE_Q30) ? ONE_Q30 : longint'(s);
  endfunction

  // Round half up: floor((v + 2^(sh-1)) / 2^sh).
  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 << (sh - 1))) >>> sh;
  endfunction

  function automatic entry_t matrix_entry(longint base, longint omc, longint p);
    longint lim, r;
    lim = 64'sd1 << FRAC;
    r = round_shift(round_shift(omc * p, FRAC) + base, 30);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return entry_t'(r);
  endfunction

  function automatic logic [143:0] rodrigues_matrix(logic [63:0] d);
    int ang, r;
    longint ax, ay, az, s, c, omc, cb;
    logic [143:0] m;
    ang = int'($signed(d[15:0]));
    ax = longint'($signed(d[31:16]));
    ay = longint'($signed(d[47:32]));
    az = longint'($signed(d[63:48]));
    r = ((ang % TURN) + TURN) % TURN;
    if (r < QUARTER) begin
      s = series_sin(r);
      c = series_sin(QUARTER - r);
    end else if (r < 2 * QUARTER) begin
      s = series_sin(2 * QUARTER - r);
      c = -series_sin(r - QUARTER);
    end else if (r < 3 * QUARTER) begin
      s = -series_sin(r - 2 * QUARTER);
      c = -series_sin(3 * QUARTER - r);
    end else begin
      s = -series_sin(TURN - r);
      c = series_sin(r - 3 * QUARTER);
    end
    omc = ONE_Q30 - c;
    cb = c <<< FRAC;
    m[15:0]    = matrix_entry(cb, omc, ax * ax);
    m[31:16]   = matrix_entry(-(az * s), omc, ax * ay);
    m[47:32]   = matrix_entry(ay * s, omc, ax * az);
    m[63:48]   = matrix_entry(az * s, omc, ax * ay);
    m[79:64]   = matrix_entry(cb, omc, ay * ay);
    m[95:80]   = matrix_entry(-(ax * s), omc, ay * az);
    m[111:96]  = matrix_entry(-(ay * s), omc, ax * az);
    m[127:112] = matrix_entry(ax * s, omc, ay * az);
    m[143:128] = matrix_entry(cb, omc, az * az);
    return m;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    matrices_checked = 0;
  end

  assign matrices_pending = expected_matrices.size();

  always @(posedge clk) begin
    logic [143:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_matrices.push_back(rodrigues_matrix(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_matrices.size() == 0) begin
          report_mismatch("matrix with no input waiting");
        end else begin
          want = expected_matrices.pop_front();
          matrices_checked++;
          for (int e = 0; e < 9; e++)
            if (m_tdata[16*e +: 16] !== want[16*e +: 16])
              report_mismatch($sformatf("entry m%0d%0d got %h want %h",
                              e / 3, e % 3, m_tdata[16*e +: 16], want[16*e +: 16]));
        end
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for axis_angle_to_rotation_matrix_unit: drives axis-angle items
// with random idling and back pressure, and gives the verdict.
// Depends on the unit's RTL and on rotation_matrix_checker.
`timescale 1ns / 1ps

module tb;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;   // angle_deg, axis_x, axis_y, axis_z from bit 0
  logic         m_tvalid;
  logic         m_tready;
  logic [143:0] m_tdata;   // m00 .. m22 row-major from bit 0

  int fail_count;
  int matrices_pending;
  int matrices_checked;

  // Percentages of idle and stall cycles for the current phase.
  int send_idle_pct;
  int recv_stall_pct;
  // While set, the receiver stays stalled so the pipeline fills up.
  bit hold_receiver;
  int idle_cycles;
  int items_sent;

  localparam int IDLE_LIMIT = 5000;

  axis_angle_to_rotation_matrix_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  rotation_matrix_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .matrices_pending(matrices_pending),
    .matrices_checked(matrices_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: stalls at random, or throughout while a long hold-off is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d matrices outstanding", matrices_pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [15:0] random_axis_component();
    case ($urandom_range(3))
      0: return 16'($urandom_range(32768) - 16384);
      1: return 16'($urandom);
      default: return 16'($urandom_range(11585) - 5792);
    endcase
  endfunction

  // Offers one transaction after a random idle gap and waits for its acceptance.
  task automatic send_item(logic [15:0] ang, logic [15:0] ax, logic [15:0] ay,
                           logic [15:0] az);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {az, ay, ax, ang};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_item();
    logic [15:0] ang;
    case ($urandom_range(4))
      0: ang = 16'($urandom);
      1: ang = 16'($urandom_range(46080) - 23040);
      default: ang = 16'($urandom_range(2 * 5760) - 5760);
    endcase
    send_item(ang, random_axis_component(), random_axis_component(),
              random_axis_component());
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (matrices_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] dir_angles [12];
    dir_angles = '{16'sd0, 16'sd5760, 16'sd11520, 16'sd17280, 16'sd23040, -16'sd23040,
                   -16'sd5760, 16'sd1, -16'sd1, 16'h7fff, 16'h8000, 16'sd2880};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    hold_receiver = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: quadrant boundaries, wrap past a full turn, field extremes,
    // principal axes and a non-unit axis that saturates.
    foreach (dir_angles[i]) send_item(dir_angles[i], 16'sd0, 16'sd0, 16'sd16384);
    send_item(16'sd2880, 16'sd16384, 16'sd0, 16'sd0);
    send_item(16'sd2880, 16'sd0, -16'sd16384, 16'sd0);
    send_item(16'sd7680, 16'sd9459, 16'sd9459, 16'sd9459);
    send_item(-16'sd7680, -16'sd9459, 16'sd9459, -16'sd9459);
    send_item(16'sd11520, 16'sd16384, 16'sd16384, 16'sd16384);
    send_item(16'sd5760, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(16'hffff, 16'h8000, 16'h7fff, 16'h8000);
    send_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_item(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    drain_results();

    // Random phases with differing idle and stall rates.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 71 : 37) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 71 : 37) : 0;
      repeat (400) send_random_item();
      // The sender pauses here until every matrix has come back.
      drain_results();
    end

    // Long receiver hold-off while items keep coming, so the input stalls.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_receiver = 1'b1;
        repeat (200) @(posedge clk);
        hold_receiver = 1'b0;
      end
      repeat (120) send_random_item();
    join
    drain_results();

    repeat (40) @(posedge clk);
    $display("Sent %0d axis-angle items across idle/stall phases and a long hold-off;",
             items_sent);
    $display("checked %0d rotation matrices entry by entry.", matrices_checked);
    if (fail_count == 0 && matrices_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
